[rtl/core/ndopt_pkg.sv]
// Package for the neighbour discovery option parser: payload structs, parse
// phases, report codes and sizing constants. No dependencies.
package ndopt_pkg;

  localparam int unsigned AREA_BYTES = 2048;
  localparam int unsigned POS_W      = $clog2(AREA_BYTES);
  localparam int unsigned OFF_W      = 11;
  localparam int unsigned BODY_W     = 11;
  localparam int unsigned MASK_W     = 9;

  localparam logic [7:0] PREFIX_TYPE       = 8'd3;
  localparam logic [7:0] MAX_OPTIONS_RESET = 8'd10;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CLS_RECORDED  = 2'd0;
  localparam logic [1:0] CLS_DUPLICATE = 2'd1;
  localparam logic [1:0] CLS_PREFIX    = 2'd2;
  localparam logic [1:0] CLS_UNKNOWN   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN  = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic KIND_OPTION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_area;
  } in_item_t;

  typedef struct packed {
    logic              report_kind;
    logic [OFF_W-1:0]  option_offset;
    logic [7:0]        option_type;
    logic [1:0]        option_class;
    logic [1:0]        parse_status;
    logic [MASK_W-1:0] types_seen;
    logic [OFF_W-1:0]  first_prefix_offset;
    logic [OFF_W-1:0]  last_prefix_offset;
    logic              is_last;
  } out_item_t;

endpackage

[rtl/core/nd_option_tlv_parser.sv]
// Top level of the neighbour discovery option parser: input register, parse
// logic, result queue and the max_options register. Depends on ndopt_pkg.

// Takes the option area one byte per transfer and walks its type-length-value
// options. Each byte is captured in an input register and parsed from there, when
// it moves its reports into a four-entry result queue whose registers feed the
// output. A byte is parsed only while the queue has room for two reports, so a
// byte can be accepted every cycle as long as the output side takes one report
// per cycle; a nonzero length byte that also ends the area yields two reports,
// which leave one after the other. No clearing pass is needed after reset.
// max_options is written through the cfg port, which is always ready and should
// be used only while the parser holds no pending work.
module nd_option_tlv_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ndopt_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ndopt_pkg::out_item_t  out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);
  import ndopt_pkg::*;

  logic              in_valid_q, in_valid_d;
  in_item_t          in_q;
  logic              in_accept, proceed;

  logic [7:0]        max_options_q;

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BODY_W-1:0] remain_q, remain_d;
  logic [7:0]        cur_type_q, cur_type_d;
  logic [POS_W-1:0]  cur_off_q, cur_off_d;
  logic [7:0]        count_q, count_d;
  logic [1:0]        stop_q, stop_d;
  logic [MASK_W-1:0] seen_q, seen_d;
  logic [POS_W-1:0]  first_q, first_d;
  logic [POS_W-1:0]  last_q, last_d;

  // values of the run after this byte, before any end-of-area clear
  phase_e            run_phase;
  logic [POS_W-1:0]  run_pos;
  logic [BODY_W-1:0] run_remain;
  logic [7:0]        run_type;
  logic [POS_W-1:0]  run_off;
  logic [7:0]        run_count;
  logic [1:0]        run_stop;
  logic [MASK_W-1:0] run_seen;
  logic [POS_W-1:0]  run_first;
  logic [POS_W-1:0]  run_last;
  logic              clear_run;

  logic              opt_push, sum_push;
  logic [1:0]        opt_class;
  logic              known_type;
  logic [BODY_W-1:0] body_dec;
  out_item_t         opt_item, sum_item;

  out_item_t         queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] qcount_q, qcount_d;
  logic              pop;

  // ---------------------------------------------------------------- input
  assign proceed    = in_valid_q && (qcount_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_stall_o = in_valid_q && !proceed;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !proceed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  // -------------------------------------------------------- configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_options_q <= MAX_OPTIONS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_options_q <= cfg_data_i;
    end
  end

  // -------------------------------------------------------------- parsing
  assign known_type = (cur_type_q == 8'd1) || (cur_type_q == 8'd2) ||
                      (cur_type_q == 8'd4) || (cur_type_q == 8'd5) ||
                      (cur_type_q == 8'd7) || (cur_type_q == 8'd8);
  assign body_dec   = (remain_q != '0) ? remain_q - BODY_W'(1) : remain_q;

  always_comb begin
    run_phase  = phase_q;
    run_remain = remain_q;
    run_type   = cur_type_q;
    run_off    = cur_off_q;
    run_count  = count_q;
    run_stop   = stop_q;
    run_seen   = seen_q;
    run_first  = first_q;
    run_last   = last_q;
    opt_push   = 1'b0;
    opt_class  = CLS_UNKNOWN;

    case (phase_q)
      PH_TYPE: begin
        run_type  = in_q.data_byte;
        run_off   = pos_q;
        run_phase = PH_LEN;
        if (in_q.last_byte) begin
          run_stop = ST_TRUNCATED;
        end
      end
      PH_LEN: begin
        if (in_q.data_byte == 8'd0) begin
          // void the parse
          run_stop  = ST_ZERO_LEN;
          run_seen  = '0;
          run_first = '0;
          run_last  = '0;
          run_phase = PH_STOP;
        end else begin
          opt_push = 1'b1;
          if (cur_type_q == PREFIX_TYPE) begin
            opt_class = CLS_PREFIX;
            if (!seen_q[PREFIX_TYPE[3:0]]) begin
              run_seen[PREFIX_TYPE[3:0]] = 1'b1;
              run_first = cur_off_q;
            end
            run_last = cur_off_q;
          end else if (known_type) begin
            if (seen_q[cur_type_q[3:0]]) begin
              opt_class = CLS_DUPLICATE;
            end else begin
              opt_class = CLS_RECORDED;
              run_seen[cur_type_q[3:0]] = 1'b1;
            end
          end
          run_remain = {in_q.data_byte, 3'b000} - BODY_W'(2);
          run_phase  = PH_BODY;
          if (count_q >= max_options_q) begin
            run_stop  = ST_LIMIT;
            run_phase = PH_STOP;
          end else begin
            run_count = count_q + 8'd1;
          end
        end
      end
      PH_BODY: begin
        run_remain = body_dec;
        if (body_dec == '0) begin
          run_phase = PH_TYPE;
        end
      end
      default: begin
        // stopped: ignore bytes until the end of the area
      end
    endcase

    run_pos = (pos_q == POS_W'(AREA_BYTES - 1)) ? '0 : pos_q + POS_W'(1);

    // an empty area abandons the run and reports nothing else
    if (in_q.empty_area) begin
      opt_push  = 1'b0;
      run_stop  = ST_OK;
      run_seen  = '0;
      run_first = '0;
      run_last  = '0;
    end
    sum_push  = in_q.empty_area || in_q.last_byte;
    clear_run = sum_push;
  end

  always_comb begin
    opt_item.report_kind         = KIND_OPTION;
    opt_item.option_offset       = OFF_W'(cur_off_q);
    opt_item.option_type         = cur_type_q;
    opt_item.option_class        = opt_class;
    opt_item.parse_status        = ST_OK;
    opt_item.types_seen          = run_seen;
    opt_item.first_prefix_offset = OFF_W'(run_first);
    opt_item.last_prefix_offset  = OFF_W'(run_last);
    opt_item.is_last             = !sum_push;

    sum_item.report_kind         = KIND_SUMMARY;
    sum_item.option_offset       = '0;
    sum_item.option_type         = '0;
    sum_item.option_class        = CLS_RECORDED;
    sum_item.parse_status        = run_stop;
    sum_item.types_seen          = run_seen;
    sum_item.first_prefix_offset = OFF_W'(run_first);
    sum_item.last_prefix_offset  = OFF_W'(run_last);
    sum_item.is_last             = 1'b1;
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    remain_d   = remain_q;
    cur_type_d = cur_type_q;
    cur_off_d  = cur_off_q;
    count_d    = count_q;
    stop_d     = stop_q;
    seen_d     = seen_q;
    first_d    = first_q;
    last_d     = last_q;
    if (proceed) begin
      if (clear_run) begin
        phase_d    = PH_TYPE;
        pos_d      = '0;
        remain_d   = '0;
        cur_type_d = '0;
        cur_off_d  = '0;
        count_d    = '0;
        stop_d     = ST_OK;
        seen_d     = '0;
        first_d    = '0;
        last_d     = '0;
      end else begin
        phase_d    = run_phase;
        pos_d      = run_pos;
        remain_d   = run_remain;
        cur_type_d = run_type;
        cur_off_d  = run_off;
        count_d    = run_count;
        stop_d     = run_stop;
        seen_d     = run_seen;
        first_d    = run_first;
        last_d     = run_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      pos_q      <= '0;
      remain_q   <= '0;
      cur_type_q <= '0;
      cur_off_q  <= '0;
      count_q    <= '0;
      stop_q     <= ST_OK;
      seen_q     <= '0;
      first_q    <= '0;
      last_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      remain_q   <= remain_d;
      cur_type_q <= cur_type_d;
      cur_off_q  <= cur_off_d;
      count_q    <= count_d;
      stop_q     <= stop_d;
      seen_q     <= seen_d;
      first_q    <= first_d;
      last_q     <= last_d;
    end
  end

  // --------------------------------------------------------- result queue
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (qcount_q != '0);
  assign out_item_o  = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    qcount_d = qcount_q;
    if (proceed) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(opt_push) + QPTR_W'(sum_push);
      qcount_d = qcount_q + QCNT_W'(opt_push) + QCNT_W'(sum_push);
    end
    rd_ptr_d = rd_ptr_q;
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
      qcount_d = qcount_d - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcount_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      qcount_q <= qcount_d;
    end
  end

  // the summary follows the option report when both are due
  always_ff @(posedge clk_i) begin
    if (proceed && opt_push) begin
      queue_q[wr_ptr_q] <= opt_item;
    end
    if (proceed && sum_push) begin
      queue_q[wr_ptr_q + QPTR_W'(opt_push)] <= sum_item;
    end
  end

endmodule

[rtl/core/ndopt_checker.sv]
// Port-level checks for the neighbour discovery option parser, bound to
// nd_option_tlv_parser. Depends on ndopt_pkg.
module ndopt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input ndopt_pkg::out_item_t out_item_o
);
  import ndopt_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.report_kind == KIND_SUMMARY) |-> out_item_o.is_last)
    else $error("summary not marked last");

  a_option_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.report_kind == KIND_OPTION)
      |-> (out_item_o.parse_status == ST_OK))
    else $error("option report carries a status");

  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.report_kind == KIND_SUMMARY)
      |-> (out_item_o.option_offset == '0) && (out_item_o.option_type == '0)
          && (out_item_o.option_class == CLS_RECORDED))
    else $error("summary carries option fields");

  // a report that is not last must be an option report followed by more
  a_not_last_option: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_last |-> (out_item_o.report_kind == KIND_OPTION))
    else $error("non-final result is not an option report");

endmodule

bind nd_option_tlv_parser ndopt_checker u_ndopt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[bench/testbench.sv]
// Self-checking bench for nd_option_tlv_parser: drives option areas byte by byte and
// checks every option report and area summary against a predictor kept in step.
// Depends on ndopt_pkg and the parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ndopt_pkg::*;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned HOLDOFF_CYCLES = 150;
  localparam int unsigned PRINT_CAP      = 100;
  // types 1, 2, 4, 5, 7 and 8 are recorded on first sight
  localparam logic [MASK_W-1:0] KNOWN_TYPES = 9'b1_1011_0110;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_e;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_item   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_ready;

  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned holdoff_reqs = 0;

  nd_option_tlv_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count++;

  // ---------------------------------------------------------------- predictor
  phase_e            walk_phase = PH_TYPE;
  logic [OFF_W-1:0]  walk_pos   = '0;
  logic [BODY_W-1:0] body_left  = '0;
  logic [7:0]        cur_type   = '0;
  logic [OFF_W-1:0]  cur_off    = '0;
  logic [7:0]        opt_count  = '0;
  logic [1:0]        stop_st    = ST_OK;
  logic [MASK_W-1:0] seen_types = '0;
  logic [OFF_W-1:0]  first_pfx  = '0;
  logic [OFF_W-1:0]  last_pfx   = '0;
  logic [7:0]        max_opts   = MAX_OPTIONS_RESET;

  out_item_t pending_reports[$];

  function automatic void clear_walk();
    walk_phase = PH_TYPE;
    walk_pos   = '0;
    body_left  = '0;
    cur_type   = '0;
    cur_off    = '0;
    opt_count  = '0;
    stop_st    = ST_OK;
    seen_types = '0;
    first_pfx  = '0;
    last_pfx   = '0;
  endfunction

  function automatic out_item_t make_report(logic kind, logic [OFF_W-1:0] off,
                                            logic [7:0] typ, logic [1:0] cls,
                                            logic [1:0] st);
    out_item_t r;
    r.report_kind         = kind;
    r.option_offset       = off;
    r.option_type         = typ;
    r.option_class        = cls;
    r.parse_status        = st;
    r.types_seen          = seen_types;
    r.first_prefix_offset = first_pfx;
    r.last_prefix_offset  = last_pfx;
    r.is_last             = 1'b0;
    return r;
  endfunction

  function automatic logic [1:0] classify_option();
    if (cur_type == PREFIX_TYPE) begin
      if (!seen_types[PREFIX_TYPE]) begin
        seen_types[PREFIX_TYPE] = 1'b1;
        first_pfx = cur_off;
      end
      last_pfx = cur_off;
      return CLS_PREFIX;
    end
    if (cur_type <= 8'd8 && KNOWN_TYPES[cur_type[3:0]]) begin
      if (seen_types[cur_type[3:0]]) return CLS_DUPLICATE;
      seen_types[cur_type[3:0]] = 1'b1;
      return CLS_RECORDED;
    end
    return CLS_UNKNOWN;
  endfunction

  function automatic void parse_area_byte(in_item_t it);
    out_item_t reps[$];
    logic [1:0] cls;
    if (it.empty_area) begin
      clear_walk();
      reps.push_back(make_report(KIND_SUMMARY, '0, '0, '0, ST_OK));
    end else begin
      case (walk_phase)
        PH_TYPE: begin
          cur_type   = it.data_byte;
          cur_off    = walk_pos;
          walk_phase = PH_LEN;
          if (it.last_byte) stop_st = ST_TRUNCATED;
        end
        PH_LEN: begin
          if (it.data_byte == 8'd0) begin
            // void the whole parse
            stop_st    = ST_ZERO_LEN;
            seen_types = '0;
            first_pfx  = '0;
            last_pfx   = '0;
            walk_phase = PH_STOP;
          end else begin
            cls = classify_option();
            reps.push_back(make_report(KIND_OPTION, cur_off, cur_type, cls, ST_OK));
            body_left  = {it.data_byte, 3'b000} - 11'd2;
            walk_phase = PH_BODY;
            if (opt_count >= max_opts) begin
              stop_st    = ST_LIMIT;
              walk_phase = PH_STOP;
            end else begin
              opt_count++;
            end
          end
        end
        PH_BODY: begin
          if (body_left != '0) body_left--;
          if (body_left == '0) walk_phase = PH_TYPE;
        end
        default: ;
      endcase
      walk_pos = walk_pos + 1'b1;
      if (it.last_byte) begin
        reps.push_back(make_report(KIND_SUMMARY, '0, '0, '0, stop_st));
        clear_walk();
      end
    end
    if (reps.size() > 0) reps[reps.size()-1].is_last = 1'b1;
    foreach (reps[i]) pending_reports.push_back(reps[i]);
  endfunction

  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready) max_opts = cfg_data;
    if (rst_ni && in_valid && !in_stall) parse_area_byte(in_item);
  end

  // ------------------------------------------------------------------ checking
  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    // keep the log short when the block is badly broken
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) flag_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("report with nothing pending, report_kind", out_item.report_kind, 0);
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", out_item.report_kind, want.report_kind);
        check_field("option_offset", out_item.option_offset, want.option_offset);
        check_field("option_type", out_item.option_type, want.option_type);
        check_field("option_class", out_item.option_class, want.option_class);
        check_field("parse_status", out_item.parse_status, want.parse_status);
        check_field("types_seen", out_item.types_seen, want.types_seen);
        check_field("first_prefix_offset", out_item.first_prefix_offset,
                    want.first_prefix_offset);
        check_field("last_prefix_offset", out_item.last_prefix_offset,
                    want.last_prefix_offset);
        check_field("is_last", out_item.is_last, want.is_last);
      end
    end
  end

  // ------------------------------------------------------------ receiver side
  stall_mode_e stall_mode   = STALL_NONE;
  int unsigned mode_left    = 0;
  int unsigned holdoff_done = 0;
  int unsigned hold_left    = 0;

  always @(posedge clk_i) begin
    if (holdoff_reqs != holdoff_done) begin
      holdoff_done++;
      hold_left = HOLDOFF_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // -------------------------------------------------------------- sender side
  // Called at a rising edge; returns at the edge of the transfer, or later when
  // a gap between bursts follows.
  task automatic send_item(logic [7:0] data, logic last, logic empty);
    in_valid <= 1'b1;
    in_item  <= '{data_byte: data, last_byte: last, empty_area: empty};
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Send one area; an empty-area transfer is slipped in before index empty_at
  // when that is non-zero.
  task automatic send_area(logic [7:0] area[$], int unsigned empty_at);
    if (area.size() == 0) begin
      send_item(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      foreach (area[i]) begin
        if (empty_at != 0 && i == empty_at) send_item(8'($urandom), 1'($urandom), 1'b1);
        send_item(area[i], i == area.size() - 1, 1'b0);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // a body byte may still sit in the input register with nothing pending
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_options(logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_area();
    logic [7:0]  area[$];
    logic [7:0]  typ;
    int unsigned n_opts;
    int unsigned len;
    int unsigned cut;
    int unsigned empty_at;
    if ($urandom_range(0, 9) == 0) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(1, 24)) area.push_back(8'($urandom));
    end else begin
      n_opts = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
      repeat (n_opts) begin
        typ = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
        case ($urandom_range(0, 19))
          0:       len = 0;
          1, 2:    len = $urandom_range(3, 12);
          default: len = $urandom_range(1, 2);
        endcase
        area.push_back(typ);
        area.push_back(8'(len));
        if (len != 0) repeat (len * 8 - 2) area.push_back(8'($urandom));
      end
      // end the area early: after a type byte, a length byte or inside a body
      if (area.size() > 1 && $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, area.size() - 1);
        while (area.size() > cut) void'(area.pop_back());
      end
    end
    empty_at = 0;
    if (area.size() > 2 && $urandom_range(0, 29) == 0)
      empty_at = $urandom_range(1, area.size() - 1);
    send_area(area, empty_at);
  endtask

  // ------------------------------------------------------------------- tests
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);                      // empty area
    send_area('{8'hFF}, 0);                            // type byte ends the area
    send_area('{PREFIX_TYPE, 8'd1}, 0);                // length byte ends the area
    send_area('{8'd1, 8'd0, 8'd5, 8'd7}, 0);           // zero length, rest ignored
    send_area('{8'd200, 8'd255, 8'd0, 8'd0}, 0);       // option runs past the end
    send_area('{8'd4, 8'd1, 8'd9, 8'd9}, 3);           // area abandoned mid-option
  endtask

  task automatic test_option_limit();
    write_max_options(8'd0);
    send_area('{8'd7, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd1}, 0);
    write_max_options(8'd1);
    // limit reached by the option that also ends the area
    send_area('{8'd1, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, PREFIX_TYPE, 8'd1}, 0);
    write_max_options(8'd255);
    repeat (3) send_random_area();
    write_max_options(MAX_OPTIONS_RESET);
  endtask

  task automatic test_backpressure();
    holdoff_reqs++;
    // every empty-area transfer yields a summary, so the result queue fills fast
    repeat (16) send_item(8'($urandom), 1'($urandom), 1'b1);
    repeat (3) send_random_area();
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned areas;
    start = items_sent;
    areas = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (areas % 12 == 11) begin
        case ($urandom_range(0, 5))
          0:       write_max_options(8'd0);
          1:       write_max_options(8'd255);
          2:       write_max_options(MAX_OPTIONS_RESET);
          3:       write_max_options(8'($urandom));
          default: write_max_options(8'($urandom_range(1, 4)));
        endcase
      end
      send_random_area();
      areas++;
    end
  endtask

  // Area longer than the offset range: positions wrap and offsets are masked.
  task automatic test_long_area();
    logic [7:0] area[$];
    write_max_options(8'd255);
    area.push_back(8'd1);
    area.push_back(8'd255);
    repeat (255 * 8 - 2) area.push_back(8'($urandom));
    repeat (2) begin
      area.push_back(PREFIX_TYPE);
      area.push_back(8'd1);
      repeat (6) area.push_back(8'($urandom));
    end
    area.push_back(8'd5);
    area.push_back(8'd1);
    repeat (6) area.push_back(8'($urandom));
    send_area(area, 0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_option_limit();
    test_backpressure();
    test_random();
    test_long_area();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS nd_option_tlv_parser");
    end else begin
      $display("FAIL nd_option_tlv_parser");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL nd_option_tlv_parser");
    $finish;
  end

endmodule
